### hw/rtl/rep_pkg.sv
// Shared types and constants for the rumble envelope pulse driver.
// Used by rep_div and rumble_envelope_pulse_driver; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rep_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 19;
    localparam int LVL_W     = FRAC_BITS + 1;
    localparam int TIME_W    = 23;
    localparam int FC_W      = 32;

    // ramp arithmetic widths
    localparam int PROD_W    = LVL_W + TIME_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int DEN_W     = TIME_W + FRAC_BITS;
    localparam int STEP_W    = $clog2(FC_W + 1);
    localparam int QUO_W     = 4;
    localparam int LOW_BITS  = 4;

    // divisor selection: 9 minus ceil(8t), clamped
    localparam logic [QUO_W-1:0] PULSE_TOP  = QUO_W'(9);
    localparam logic [QUO_W-1:0] CEIL_MAX   = QUO_W'(8);
    localparam logic [QUO_W-1:0] DIV_ALWAYS = QUO_W'(1);

    localparam logic [LVL_W-1:0] LVL_ONE    = LVL_W'(1) << FRAC_BITS;
    localparam int               TENTH_MUL  = 10;

    localparam int FRAME_RATE_DEF = 60;

    // item commands
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_ADV  = 2'd2
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODF,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_CDIV,
        ST_MODD,
        ST_FIN
    } rep_state_t;

    // divider request and status
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/rumble_envelope_pulse_driver.sv
// Top level of the rumble envelope pulse driver: sequencer, ramp state, item ports.
// Depends on rep_pkg and rep_div.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: cmd selects frame tick (0),
//   ramp load (1) or time advance (2). Every item returns exactly one result on
//   out_valid/out_ready: drive_on, issue_start, issue_stop, issue_init, link_up,
//   load_taken. The enable register is written through cfg_we/cfg_wdata.
//   A load or advance item goes from acceptance to the finish state and then
//   into the output register. A frame tick makes two 32-step passes of the shared
//   divider (frame count mod FRAME_RATE, then frame count mod pulse divisor), a
//   4-step divide for ceil(8t), and two products on the shared multiplier. Ticks
//   that need no pulse divisor finish earlier. One item is in work at a time;
//   in_ready is high only while the sequencer is idle.
//   A finished result sits in the output register; the next item is accepted
//   while it waits, and the sequencer holds its next result until the output
//   register is taken. Reset clears frame count, drive, link, ramp state,
//   enable and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module rumble_envelope_pulse_driver #(
    parameter int FRAME_RATE = rep_pkg::FRAME_RATE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  cmd,
    input  wire logic [rep_pkg::LVL_W-1:0]   start_level,
    input  wire logic [rep_pkg::LVL_W-1:0]   end_level,
    input  wire logic [rep_pkg::TIME_W-1:0]  ramp_time,
    input  wire logic                        special_mode,
    input  wire logic [rep_pkg::TIME_W-1:0]  time_step,
    input  wire logic                        motor_ok,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             drive_on,
    output logic                             issue_start,
    output logic                             issue_stop,
    output logic                             issue_init,
    output logic                             link_up,
    output logic                             load_taken
);
    import rep_pkg::*;

    localparam logic [DEN_W-1:0] FR_DIV = DEN_W'(FRAME_RATE);

    rep_state_t state_reg, state_next;

    // architectural state
    logic              enable_reg;
    logic [FC_W-1:0]   frame_count_reg, frame_count_next;
    logic              pulse_reg, pulse_next;
    logic              link_reg, link_next;
    logic [TIME_W-1:0] length_reg, length_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [LVL_W-1:0]  from_reg, from_next;
    logic [LVL_W-1:0]  to_reg, to_next;

    // per-item working registers
    logic              tick_reg, tick_next;
    logic              ok_reg, ok_next;
    logic              ini_reg, ini_next;
    logic              taken_reg, taken_next;
    logic              drv_reg, drv_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // output register
    logic out_valid_reg, out_valid_next;
    logic drive_on_reg, drive_on_next;
    logic start_reg, start_next;
    logic stop_reg, stop_next;
    logic init_reg, init_next;
    logic link_up_reg, link_up_next;
    logic taken_out_reg, taken_out_next;

    // divider hookup
    div_ctl_t          div_ctl;
    div_stat_t         div_st;
    logic [DEN_W-1:0]  div_init;
    logic [FC_W-1:0]   div_bits;
    logic [DEN_W-1:0]  div_dvs;
    logic [DEN_W-1:0]  div_rem;
    logic [QUO_W-1:0]  div_quo;

    // datapath helpers
    logic              accept;
    logic              out_free;
    logic [LVL_W-1:0]  s_lvl, e_lvl;
    logic [TIME_W-1:0] remain;
    logic [TIME_W+3:0] remain10;
    logic              long_left, weaker;
    logic [TIME_W:0]   adv_sum;
    logic [LVL_W-1:0]  mul_a;
    logic [TIME_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [SUM_W-1:0]  num_half;
    logic [QUO_W-1:0]  ceil_c, ceil_cl, pulse_div;
    logic              chg;

    rep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .init_rem (div_init),
        .bits     (div_bits),
        .divisor  (div_dvs),
        .stat     (div_st),
        .rem      (div_rem),
        .quo      (div_quo)
    );

    // input field conditioning and ramp arithmetic
    always_comb
    begin
        accept   = in_valid && in_ready;
        out_free = !out_valid_reg || out_ready;
        s_lvl    = (start_level > LVL_ONE) ? LVL_ONE : start_level;
        e_lvl    = (end_level > LVL_ONE) ? LVL_ONE : end_level;
        remain   = length_reg - elapsed_reg;
        remain10 = (TIME_W+4)'(remain) * (TIME_W+4)'(TENTH_MUL);
        long_left = (remain10 > (TIME_W+4)'(LVL_ONE));
        weaker   = ({1'b0, s_lvl} + {1'b0, e_lvl}) < ({1'b0, from_reg} + {1'b0, to_reg});
        adv_sum  = {1'b0, elapsed_reg} + {1'b0, time_step};
        mul_a    = (state_reg == ST_MUL1) ? from_reg : to_reg;
        mul_b    = (state_reg == ST_MUL1) ? remain : elapsed_reg;
        mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
        num_half = SUM_W'(acc_reg) + SUM_W'(prod_reg);
        ceil_c   = div_quo + ((div_rem != '0) ? QUO_W'(1) : QUO_W'(0));
        ceil_cl  = (ceil_c > CEIL_MAX) ? CEIL_MAX : ceil_c;
        pulse_div = PULSE_TOP - ceil_cl;
        chg      = tick_reg && (drv_reg != pulse_reg) && link_reg;
    end

    // sequencer: next state, state updates and divider requests
    always_comb
    begin
        state_next       = state_reg;
        frame_count_next = frame_count_reg;
        pulse_next       = pulse_reg;
        link_next        = link_reg;
        length_next      = length_reg;
        elapsed_next     = elapsed_reg;
        from_next        = from_reg;
        to_next          = to_reg;
        tick_next        = tick_reg;
        ok_next          = ok_reg;
        ini_next         = ini_reg;
        taken_next       = taken_reg;
        drv_next         = drv_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        drive_on_next    = drive_on_reg;
        start_next       = start_reg;
        stop_next        = stop_reg;
        init_next        = init_reg;
        link_up_next     = link_up_reg;
        taken_out_next   = taken_out_reg;
        div_ctl.start    = 1'b0;
        div_ctl.steps    = STEP_W'(FC_W);
        div_init         = '0;
        div_bits         = frame_count_reg;
        div_dvs          = FR_DIV;
        in_ready         = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tick_next  = 1'b0;
                    ok_next    = motor_ok;
                    ini_next   = 1'b0;
                    taken_next = 1'b0;
                    state_next = ST_FIN;
                    if (cmd == CMD_TICK)
                    begin
                        tick_next        = 1'b1;
                        frame_count_next = frame_count_reg + FC_W'(1);
                        div_ctl.start    = 1'b1;
                        div_bits         = frame_count_next;
                        state_next       = ST_MODF;
                    end
                    else if (cmd == CMD_SET)
                    begin
                        if ((ramp_time != '0) && enable_reg && !special_mode
                            && (!long_left || !weaker))
                        begin
                            length_next  = ramp_time;
                            elapsed_next = '0;
                            from_next    = s_lvl;
                            to_next      = e_lvl;
                            taken_next   = 1'b1;
                        end
                    end
                    else if (cmd == CMD_ADV)
                    begin
                        if (enable_reg)
                        begin
                            elapsed_next = (adv_sum > {1'b0, length_reg}) ?
                                           length_reg : adv_sum[TIME_W-1:0];
                        end
                    end
                end
            end
            ST_MODF:
            begin
                if (div_st.done)
                begin
                    if (!link_reg && (div_rem == '0))
                    begin
                        ini_next  = 1'b1;
                        link_next = ok_reg;
                    end
                    if ((length_reg == '0) || (elapsed_reg == length_reg))
                    begin
                        drv_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                acc_next   = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // num = 8 * sum; the top part seeds the remainder, four bits shift in
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(LOW_BITS);
                div_init      = num_half[DEN_W:1];
                div_bits      = {num_half[0], {(FC_W-1){1'b0}}};
                div_dvs       = {length_reg, {FRAC_BITS{1'b0}}};
                state_next    = ST_CDIV;
            end
            ST_CDIV:
            begin
                if (div_st.done)
                begin
                    if (pulse_div <= DIV_ALWAYS)
                    begin
                        drv_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        div_ctl.start = 1'b1;
                        div_dvs       = DEN_W'(pulse_div);
                        state_next    = ST_MODD;
                    end
                end
            end
            ST_MODD:
            begin
                if (div_st.done)
                begin
                    drv_next   = (div_rem == '0);
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (tick_reg)
                    begin
                        pulse_next = drv_reg;
                    end
                    if (chg)
                    begin
                        link_next = ok_reg;
                    end
                    out_valid_next = 1'b1;
                    drive_on_next  = tick_reg ? drv_reg : pulse_reg;
                    start_next     = chg && drv_reg;
                    stop_next      = chg && !drv_reg;
                    init_next      = tick_reg && ini_reg;
                    link_up_next   = chg ? ok_reg : link_reg;
                    taken_out_next = taken_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            enable_reg      <= 1'b0;
            frame_count_reg <= '0;
            pulse_reg       <= 1'b0;
            link_reg        <= 1'b0;
            length_reg      <= '0;
            elapsed_reg     <= '0;
            from_reg        <= '0;
            to_reg          <= '0;
            out_valid_reg   <= 1'b0;
            drive_on_reg    <= 1'b0;
            start_reg       <= 1'b0;
            stop_reg        <= 1'b0;
            init_reg        <= 1'b0;
            link_up_reg     <= 1'b0;
            taken_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            frame_count_reg <= frame_count_next;
            pulse_reg       <= pulse_next;
            link_reg        <= link_next;
            length_reg      <= length_next;
            elapsed_reg     <= elapsed_next;
            from_reg        <= from_next;
            to_reg          <= to_next;
            out_valid_reg   <= out_valid_next;
            drive_on_reg    <= drive_on_next;
            start_reg       <= start_next;
            stop_reg        <= stop_next;
            init_reg        <= init_next;
            link_up_reg     <= link_up_next;
            taken_out_reg   <= taken_out_next;
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        tick_reg  <= tick_next;
        ok_reg    <= ok_next;
        ini_reg   <= ini_next;
        taken_reg <= taken_next;
        drv_reg   <= drv_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
    end

    assign out_valid   = out_valid_reg;
    assign drive_on    = drive_on_reg;
    assign issue_start = start_reg;
    assign issue_stop  = stop_reg;
    assign issue_init  = init_reg;
    assign link_up     = link_up_reg;
    assign load_taken  = taken_out_reg;

    // elapsed time never passes the ramp length
    a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg <= length_reg)
        else $error("elapsed beyond ramp length");

    // a start command always goes with the drive on, a stop with it off
    a_cmd_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (issue_start || issue_stop) |-> (issue_start == drive_on))
        else $error("motor command disagrees with drive state");

    // the shared divider is free whenever a new item can be taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_st.busy)
        else $error("divider busy while sequencer idle");

endmodule

`default_nettype wire

### hw/rtl/rep_div.sv
// Shared restoring divide unit, one quotient bit per cycle.
// Depends on rep_pkg for widths and the request/status structs.
`timescale 1ns / 1ps
`default_nettype none

module rep_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rep_pkg::div_ctl_t        ctl,
    input  wire logic [rep_pkg::DEN_W-1:0] init_rem,
    input  wire logic [rep_pkg::FC_W-1:0]  bits,
    input  wire logic [rep_pkg::DEN_W-1:0] divisor,
    output rep_pkg::div_stat_t            stat,
    output logic [rep_pkg::DEN_W-1:0]     rem,
    output logic [rep_pkg::QUO_W-1:0]     quo
);
    import rep_pkg::*;

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [FC_W-1:0]   shf_reg;
    logic [DEN_W-1:0]  dvs_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic              busy;

    // one compare and subtract per cycle
    always_comb
    begin
        trial = {rem_reg, shf_reg[FC_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
        busy  = (cnt_reg != '0);
    end

    // step counter and done pulse
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            cnt_next = ctl.steps;
        end
        else if (busy)
        begin
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= init_rem;
            shf_reg <= bits;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            shf_reg <= {shf_reg[FC_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign stat = '{busy: busy, done: done_reg};
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire
